// File: rtl/sparse_gap_rice_encoder_defines.svh
// Assertion macros shared by the sparse gap Rice encoder modules.
`ifndef SPARSE_GAP_RICE_ENCODER_DEFINES_SVH
`define SPARSE_GAP_RICE_ENCODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SGRE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SGRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGRE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SGRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/sgre_pkg.sv
// Types and constants shared by the sparse gap Rice encoder modules.
package sgre_pkg;

   localparam int RICE_K_W    = 3;
   localparam int POSITION_W  = 16;
   localparam int BYTE_W      = 8;
   localparam int QUOT_MAX    = 255;
   localparam logic [RICE_K_W-1:0] RICE_K_RESET = 3'd4;

   typedef struct packed {
      logic [POSITION_W-1:0] position;
      logic                  is_first;
      logic                  is_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ONES,
      ST_TAIL,
      ST_FLUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step_ones;
      logic step_tail;
      logic flush;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_ones;
      logic out_free;
      logic ones_finish;
      logic tail_finish;
      logic tail_fill;
      logic last;
   } sts_type;

endpackage

// File: rtl/sgre_ctrl.sv
// Controller state machine of the sparse gap Rice encoder.
`include "sparse_gap_rice_encoder_defines.svh"
module sgre_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sgre_pkg::sts_type sts,
   output sgre_pkg::cmd_type cmd
);
   import sgre_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.load_ones ? ST_ONES : ST_TAIL;
            end
         end
         ST_ONES: begin
            if (sts.out_free && sts.ones_finish) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (sts.out_free && sts.tail_finish) begin
               state_in = (sts.last && !sts.tail_fill) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_ONES: begin
            cmd.step_ones = sts.out_free;
         end
         ST_TAIL: begin
            cmd.step_tail = sts.out_free;
         end
         ST_FLUSH: begin
            cmd.flush = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   `SGRE_ASSERT_IMPL(a_cmd_onehot, clock, reset, 1'b1,
      $onehot0({cmd.load, cmd.step_ones, cmd.step_tail, cmd.flush}),
      "more than one datapath command at once")
   `SGRE_ASSERT_NEXT(a_flush_to_idle, clock, reset, cmd.flush,
      state_ff == ST_IDLE, "controller did not return to idle after a flush")

endmodule

// File: rtl/sgre_datapath.sv
// Datapath of the sparse gap Rice encoder: gap coding, bit packing, output register.
`include "sparse_gap_rice_encoder_defines.svh"
module sgre_datapath #(
   parameter int FIRST_POSITION_BITS = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sgre_pkg::req_type                req_data,
   input  sgre_pkg::cmd_type                cmd,
   output sgre_pkg::sts_type                sts,
   input  logic                             csr_write_enable,
   input  logic [sgre_pkg::RICE_K_W-1:0]    csr_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sgre_pkg::rsp_type                rsp_data
);
   import sgre_pkg::*;

   localparam int HDR_W  = RICE_K_W + FIRST_POSITION_BITS;
   localparam int TAIL_W = (HDR_W > BYTE_W) ? HDR_W : BYTE_W;
   localparam int TL_W   = $clog2(TAIL_W + 1);

   logic [RICE_K_W-1:0]   rice_k_ff,    rice_k_in;
   logic [6:0]            pend_bits_ff, pend_bits_in;
   logic [2:0]            pend_cnt_ff,  pend_cnt_in;
   logic [POSITION_W-1:0] prev_pos_ff,  prev_pos_in;
   logic                  in_vector_ff, in_vector_in;
   logic                  last_ff,      last_in;
   logic [7:0]            ones_left_ff, ones_left_in;
   logic [TAIL_W-1:0]     tail_ff,      tail_in;
   logic [TL_W-1:0]       tail_left_ff, tail_left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   logic                  header_sel;
   logic [POSITION_W-1:0] gap;
   logic [POSITION_W-1:0] quot_full;
   logic                  clamp;
   logic [7:0]            quot;
   logic [6:0]            rem_bits;
   logic [6:0]            rem_just;
   logic [HDR_W-1:0]      hdr_bits;
   logic [3:0]            avail;
   logic [3:0]            ones_take;
   logic [3:0]            tail_take;
   logic [3:0]            take;
   logic [7:0]            chunk;
   logic [7:0]            merged;
   logic [3:0]            fill;
   logic                  byte_full;
   logic                  out_free;

   // Gap coding of the offered item.
   always_comb begin
      header_sel = req_data.is_first || !in_vector_ff;
      gap        = req_data.position - prev_pos_ff - 16'd1;
      quot_full  = gap >> rice_k_ff;
      clamp      = quot_full > 16'(QUOT_MAX);
      quot       = clamp ? 8'(QUOT_MAX) : quot_full[7:0];
      rem_bits   = clamp ? 7'd0 : (gap[6:0] & ((7'd1 << rice_k_ff) - 7'd1));
      rem_just   = rem_bits << (3'd7 - rice_k_ff);
      hdr_bits   = {rice_k_ff, req_data.position[FIRST_POSITION_BITS-1:0]};
   end

   // Packing of up to one byte per cycle while the output register is free.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      avail     = 4'd8 - {1'b0, pend_cnt_ff};
      ones_take = (ones_left_ff < 8'(avail)) ? ones_left_ff[3:0] : avail;
      tail_take = (tail_left_ff < TL_W'(avail)) ? tail_left_ff[3:0] : avail;
      take      = cmd.step_tail ? tail_take : ones_take;
      chunk     = cmd.step_tail ? tail_ff[TAIL_W-1 -: 8] : 8'hFF;
      merged    = (8'(pend_bits_ff) << take) | (chunk >> (4'd8 - take));
      fill      = {1'b0, pend_cnt_ff} + take;
      byte_full = fill == 4'd8;
   end

   always_comb begin
      sts.load_ones   = !header_sel && (quot != 8'd0);
      sts.out_free    = out_free;
      sts.ones_finish = ones_left_ff <= 8'(avail);
      sts.tail_finish = tail_left_ff <= TL_W'(avail);
      sts.tail_fill   = ({1'b0, pend_cnt_ff} + tail_take) == 4'd8;
      sts.last        = last_ff;
   end

   always_comb begin
      rice_k_in    = csr_write_enable ? csr_write_data : rice_k_ff;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      prev_pos_in  = prev_pos_ff;
      in_vector_in = in_vector_ff;
      last_in      = last_ff;
      ones_left_in = ones_left_ff;
      tail_in      = tail_ff;
      tail_left_in = tail_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         prev_pos_in  = req_data.position;
         in_vector_in = !req_data.is_last;
         last_in      = req_data.is_last;
         if (header_sel) begin
            pend_bits_in = 7'd0;
            pend_cnt_in  = 3'd0;
            ones_left_in = 8'd0;
            tail_in      = TAIL_W'(hdr_bits) << (TAIL_W - HDR_W);
            tail_left_in = TL_W'(HDR_W);
         end else begin
            ones_left_in = quot;
            tail_in      = TAIL_W'({1'b0, rem_just}) << (TAIL_W - BYTE_W);
            tail_left_in = TL_W'(rice_k_ff) + TL_W'(1);
         end
      end

      if (cmd.step_ones || cmd.step_tail) begin
         if (cmd.step_ones) begin
            ones_left_in = ones_left_ff - 8'(take);
         end else begin
            tail_in      = tail_ff << take;
            tail_left_in = tail_left_ff - TL_W'(take);
         end
         if (byte_full) begin
            pend_bits_in          = 7'd0;
            pend_cnt_in           = 3'd0;
            rsp_valid_in          = 1'b1;
            rsp_data_in.out_byte  = merged;
            rsp_data_in.last_byte = cmd.step_tail && last_ff && sts.tail_finish;
         end else begin
            pend_bits_in = merged[6:0];
            pend_cnt_in  = fill[2:0];
         end
      end

      if (cmd.flush) begin
         pend_bits_in          = 7'd0;
         pend_cnt_in           = 3'd0;
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = 8'(pend_bits_ff) << (4'd8 - {1'b0, pend_cnt_ff});
         rsp_data_in.last_byte = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_k_ff    <= RICE_K_RESET;
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
         prev_pos_ff  <= '0;
         in_vector_ff <= 1'b0;
         last_ff      <= 1'b0;
         ones_left_ff <= 8'd0;
         tail_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rice_k_ff    <= rice_k_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         prev_pos_ff  <= prev_pos_in;
         in_vector_ff <= in_vector_in;
         last_ff      <= last_in;
         ones_left_ff <= ones_left_in;
         tail_left_ff <= tail_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SGRE_ASSERT_IMPL(a_ones_nonzero, clock, reset, cmd.step_ones,
      ones_left_ff != 8'd0, "unary step with no ones left")
   `SGRE_ASSERT_NEXT(a_final_empty, clock, reset,
      (cmd.flush || (cmd.step_tail && byte_full && last_ff && sts.tail_finish)),
      pend_cnt_ff == 3'd0, "bits still pending after the final byte")

endmodule

// File: rtl/sparse_gap_rice_encoder.sv
// Top level of the sparse gap Rice encoder.
//
// The block packs the ascending indices of one sparse vector's nonzero
// elements into a byte stream, first bit in the MSB of each byte. Each input
// beat on req_* carries one index with its first and last marks; each output
// beat on rsp_* carries one stream byte, and last_byte marks the final byte
// of a vector. Both channels move a beat when valid is high and stall is low.
// The user writes the Rice parameter through csr_write_enable and csr_write_data
// only while the block is idle, which the block leaves unchecked; it resets to four.
// One index is worked on at a time. Accepting it is the first step; then the
// packer adds up to one byte's worth of bits per cycle while the output register
// is free: one step per run of unary ones that fills the free part of the byte,
// one or more for the remainder or header bits, and one more for the padded byte
// at the end of a vector. A finished byte is loaded into the output register by
// the step that completes it. A stall on rsp holds the output register and
// freezes the packer until the byte is taken, and req_stall stays high while
// an index is in work. Reset closes any open vector and drops its bits.
module sparse_gap_rice_encoder #(
   parameter int FIRST_POSITION_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sgre_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sgre_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [sgre_pkg::RICE_K_W-1:0] csr_write_data
);
   import sgre_pkg::*;

   // Commands and status between the controller and the datapath.
   cmd_type cmd;
   sts_type sts;

   sgre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sgre_datapath #(
      .FIRST_POSITION_BITS (FIRST_POSITION_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

// File: tb/sparse_gap_rice_encoder_tb.sv
// Self-checking testbench for the sparse gap Rice encoder byte stream.
`timescale 1ns / 1ps

module sparse_gap_rice_encoder_tb;
   import sgre_pkg::*;

   // The block is built with the standard first-index width of eleven bits.
   localparam int FIRST_POSITION_BITS = 11;

   // The slowest index is one with a clamped quotient; this many quiet cycles
   // after the last byte leave the block safely idle.
   localparam int SETTLE_CYCLES = 64;

   // Roughly 200 indices, each at worst 34 bytes behind receiver stalls plus
   // sender gaps, stays far below this bound.
   localparam int CYCLE_LIMIT = 400000;

   localparam int RANDOM_INDICES = 160;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [RICE_K_W-1:0] csr_write_data = '0;

   // Shadow of the encoder: the Rice parameter it will use, the bits that do
   // not yet make a whole byte (newest bit in the LSB), the previous index and
   // whether a vector is open. These mirror the block's reset values.
   logic [RICE_K_W-1:0]   rice_k_shadow = RICE_K_RESET;
   logic [BYTE_W-1:0]     partial_byte = '0;
   int                    partial_count = 0;
   logic [POSITION_W-1:0] prior_position = '0;
   logic                  vector_open = 1'b0;

   // Stream bytes that the encoder owes us, oldest first.
   rsp_type stream_bytes_due[$];

   int   mismatches = 0;
   int   burst_left = 0;
   int   cycle_count = 0;

   sparse_gap_rice_encoder #(
      .FIRST_POSITION_BITS(FIRST_POSITION_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Shift one bit into the partial byte; a full byte becomes due at once.
   function automatic void pack_bit(input logic b);
      rsp_type full;
      partial_byte = {partial_byte[BYTE_W-2:0], b};
      partial_count++;
      if (partial_count == BYTE_W) begin
         full.out_byte = partial_byte;
         full.last_byte = 1'b0;
         stream_bytes_due.push_back(full);
         partial_byte = '0;
         partial_count = 0;
      end
   endfunction

   // Pack the low nbits of value, most significant bit first.
   function automatic void pack_field(input logic [POSITION_W-1:0] value, input int nbits);
      for (int i = nbits - 1; i >= 0; i--)
         pack_bit(value[i]);
   endfunction

   // Work out the bytes that one accepted index beat adds to the stream.
   function automatic void encode_index(input req_type item);
      logic [POSITION_W-1:0] gap;
      logic [POSITION_W-1:0] remainder;
      int                    quotient;
      int                    queued_before;
      rsp_type               tail;
      queued_before = stream_bytes_due.size();
      if (item.is_first || !vector_open) begin
         // A new vector (or a later index with none open) drops any partial
         // bits and starts with the parameter and the low bits of the index.
         partial_byte = '0;
         partial_count = 0;
         pack_field(POSITION_W'(rice_k_shadow), RICE_K_W);
         pack_field(item.position, FIRST_POSITION_BITS);
         vector_open = 1'b1;
      end else begin
         // The gap wraps at sixteen bits, so a descending index is still coded.
         gap = item.position - prior_position - 1'b1;
         quotient = int'(gap >> rice_k_shadow);
         remainder = gap & ((16'd1 << rice_k_shadow) - 16'd1);
         if (quotient > QUOT_MAX) begin
            quotient = QUOT_MAX;
            remainder = '0;
         end
         repeat (quotient) pack_bit(1'b1);
         pack_bit(1'b0);
         pack_field(remainder, int'(rice_k_shadow));
      end
      prior_position = item.position;
      if (item.is_last) begin
         // Pad the partial byte with zeros. When the stream is already byte
         // aligned, the last whole byte of this beat carries the mark instead.
         if (partial_count > 0) begin
            tail.out_byte = partial_byte << (BYTE_W - partial_count);
            tail.last_byte = 1'b0;
            stream_bytes_due.push_back(tail);
            partial_byte = '0;
            partial_count = 0;
         end
         if (stream_bytes_due.size() > queued_before) begin
            tail = stream_bytes_due.pop_back();
            tail.last_byte = 1'b1;
            stream_bytes_due.push_back(tail);
         end
         vector_open = 1'b0;
      end
   endfunction

   // Offer one index beat. The sender runs in bursts; between most bursts valid
   // drops for a random number of cycles. Within a burst valid stays high
   // from one beat to the next, so it is never lowered and raised in one step.
   task automatic send_index(input logic [POSITION_W-1:0] position,
                             input logic open_mark, input logic close_mark);
      req_type item;
      int      idle_gap;
      item.position = position;
      item.is_first = open_mark;
      item.is_last = close_mark;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (idle_gap > 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      encode_index(item);
   endtask

   // Let every owed byte arrive, then give the packer time to finish an index
   // that adds bits without completing a byte.
   task automatic wait_stream_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (stream_bytes_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Rice parameter writes happen only with the block idle.
   task automatic set_rice_k(input logic [RICE_K_W-1:0] k);
      wait_stream_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= k;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      rice_k_shadow = k;
   endtask

   // One-index vectors under the reset parameter: the widest eleven-bit
   // index, an index with bits above the header field, zero, and a later
   // index that arrives with no vector open.
   task automatic test_single_index_vectors();
      send_index(16'h07FF, 1'b1, 1'b1);
      send_index(16'hFFFF, 1'b1, 1'b1);
      send_index(16'h0000, 1'b1, 1'b1);
      send_index(16'h0A5A, 1'b0, 1'b1);
   endtask

   // Gaps that wrap around sixteen bits and a quotient that must be clamped.
   task automatic test_wrap_and_clamp();
      send_index(16'hFFFF, 1'b1, 1'b0);
      send_index(16'h0000, 1'b0, 1'b0);
      send_index(16'h0001, 1'b0, 1'b0);
      send_index(16'hFFFF, 1'b0, 1'b1);
   endtask

   // With the parameter at four, a 14-bit header and a gap of 80 (five ones,
   // a zero, four remainder bits) end exactly on a byte boundary.
   task automatic test_aligned_flush();
      send_index(16'd10, 1'b1, 1'b0);
      send_index(16'd91, 1'b0, 1'b1);
   endtask

   // A first mark inside an open vector abandons it; then a descending index.
   task automatic test_restart_and_descend();
      send_index(16'd200, 1'b1, 1'b0);
      send_index(16'd300, 1'b0, 1'b0);
      send_index(16'd5, 1'b1, 1'b0);
      send_index(16'd3, 1'b0, 1'b0);
      send_index(16'd4, 1'b0, 1'b1);
   endtask

   // Both ends of the parameter range, each with a clamped quotient.
   task automatic test_rice_k_extremes();
      set_rice_k(3'd0);
      send_index(16'd1, 1'b1, 1'b0);
      send_index(16'd2, 1'b0, 1'b0);
      send_index(16'd1000, 1'b0, 1'b1);
      set_rice_k(3'd7);
      send_index(16'd0, 1'b1, 1'b0);
      send_index(16'hFFFF, 1'b0, 1'b1);
   endtask

   // The parameter changes while a vector is open; later gaps use the new one.
   task automatic test_k_change_mid_vector();
      set_rice_k(3'd2);
      send_index(16'd40, 1'b1, 1'b0);
      set_rice_k(3'd6);
      send_index(16'd140, 1'b0, 1'b0);
      send_index(16'd141, 1'b0, 1'b1);
   endtask

   // One random vector. Most are well formed with gaps scaled to the current
   // parameter; some carry random marks, lose their last mark or miss their
   // first mark. Now and then an index jumps anywhere or the gap is so large
   // that the quotient is clamped.
   task automatic send_random_vector(output int sent);
      logic [POSITION_W-1:0] position;
      logic                  open_mark;
      logic                  close_mark;
      int                    flavor;
      int                    length;
      int                    pick;
      flavor = $urandom_range(0, 9);
      length = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
      position = ($urandom_range(0, 3) == 0) ? POSITION_W'($urandom)
                                              : POSITION_W'($urandom_range(0, 2047));
      for (int i = 0; i < length; i++) begin
         open_mark = (i == 0) && (flavor != 9);
         close_mark = (i == length - 1) && (flavor != 8);
         if (flavor == 7) begin
            open_mark = ($urandom_range(0, 5) == 0);
            close_mark = ($urandom_range(0, 5) == 0);
         end
         send_index(position, open_mark, close_mark);
         pick = $urandom_range(0, 15);
         if (pick == 0)
            position = POSITION_W'($urandom);
         else if (pick == 1)
            position = position
                     + POSITION_W'($urandom_range((256 << rice_k_shadow) + 1, 65535));
         else
            position = position + POSITION_W'($urandom_range(1, 4 << rice_k_shadow));
      end
      sent = length;
   endtask

   // Random vectors in phases; each phase writes a new parameter, starting
   // with the two extremes.
   task automatic test_random_vectors();
      int phase;
      int phase_count;
      int total;
      int sent;
      phase = 0;
      total = 0;
      while (total < RANDOM_INDICES) begin
         case (phase)
            0: begin
               set_rice_k(3'd7);
            end
            1: begin
               set_rice_k(3'd0);
            end
            default: begin
               set_rice_k(RICE_K_W'($urandom_range(0, 7)));
            end
         endcase
         phase_count = 0;
         while (phase_count < 32 && total < RANDOM_INDICES) begin
            send_random_vector(sent);
            phase_count += sent;
            total += sent;
         end
         phase++;
      end
   endtask

   // The receiver switches among stretches of no stalls, light and heavy
   // random stalls, and a fixed five-in-eight stall pattern.
   initial begin : rsp_stall_pattern
      int mode;
      int stretch;
      int beat_phase;
      beat_phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         stretch = $urandom_range(16, 160);
         repeat (stretch) begin
            @(posedge clock);
            beat_phase = (beat_phase + 1) % 8;
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 1) == 0);
               end
               default: begin
                  rsp_stall <= (beat_phase < 5);
               end
            endcase
         end
      end
   end

   // Every byte beat taken from the block is compared with the oldest byte
   // owed. Values read right after the edge are those the edge acted on.
   always @(posedge clock) begin
      rsp_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stream_bytes_due.size() == 0) begin
            $display("%0t: byte beat with none owed: expected none, actual %02h last %0b",
                     $time, rsp_data.out_byte, rsp_data.last_byte);
            mismatches++;
         end else begin
            owed = stream_bytes_due.pop_front();
            if (rsp_data.out_byte !== owed.out_byte) begin
               $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                        $time, owed.out_byte, rsp_data.out_byte);
               mismatches++;
            end
            if (rsp_data.last_byte !== owed.last_byte) begin
               $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                        $time, owed.last_byte, rsp_data.last_byte);
               mismatches++;
            end
         end
      end
   end

   // A hung handshake ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sparse_gap_rice_encoder_tb failed");
      $finish;
   end

   initial begin : main_sequence
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_index_vectors();
      test_wrap_and_clamp();
      test_aligned_flush();
      test_restart_and_descend();
      test_rice_k_extremes();
      test_k_change_mid_vector();
      test_random_vectors();
      wait_stream_idle();
      if (mismatches == 0 && stream_bytes_due.size() == 0) begin
         $display("sparse_gap_rice_encoder_tb passed");
      end else begin
         $display("sparse_gap_rice_encoder_tb failed");
      end
      $finish;
   end

endmodule
